>>> hdl/reading_change_plausibility_check_assert.svh
// Assertion macros for the checker file of the reading change check.
`ifndef READING_CHANGE_PLAUSIBILITY_CHECK_ASSERT_SVH
`define READING_CHANGE_PLAUSIBILITY_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCPC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("reading change check: property violated");

// Consequent must hold in the cycle after the antecedent.
`define RCPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("reading change check: property violated");

`endif

>>> hdl/rcpc_pkg.sv
package rcpc_pkg;

    // Field and register widths
    localparam int VAL_W      = 16;
    localparam int PCT_W      = 14;
    localparam int IDX_W      = 8;
    localparam int SLOT_W     = 2;
    localparam int CODE_W     = 3;
    localparam int RATIO_W    = 23;
    localparam int RPT_W      = 8;
    localparam int CNT_W      = 16;
    localparam int NUM_CODES  = 5;
    localparam int EN_MAX     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider numerator holds value * 100, product holds (value + 1) * limit
    localparam int NUM_W = VAL_W + 7;
    localparam int MUL_W = VAL_W + 1 + PCT_W;

    localparam int HUNDRED = 100;

    // Parameter defaults
    localparam int BUS_SLOTS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 16;

    // Register reset values
    localparam logic [VAL_W-1:0]      MAX_RST = '1;
    localparam logic [PCT_W-1:0]      PCT_RST = PCT_W'(200);
    localparam logic [CFG_DATA_W-1:0] MAP_RST = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_VALUE,
        REG_PERCENT_LIMIT,
        REG_CHANNEL_MAP,
        REG_BUS_ENABLE,
        REG_REPEAT_COUNT
    } cfg_reg_t;

    typedef enum logic [CODE_W-1:0] {
        WARN_OK,
        WARN_ZERO,
        WARN_MAX,
        WARN_GROWTH,
        WARN_DECLINE,
        WARN_REPEAT
    } warn_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_HI,
        ST_CMP_HI,
        ST_MUL_LO,
        ST_CMP_LO,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } seq_state_t;

endpackage

>>> hdl/rcpc_div.sv
module rcpc_div
    import rcpc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [VAL_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W);

    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  den_reg;
    logic [VAL_W:0]    trial;
    logic              fits;

    // Bring down the next numerator bit and try the subtraction
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Control: one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: shift numerator out, quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? VAL_W'(trial - {1'b0, den_reg}) : VAL_W'(trial);
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> hdl/reading_change_plausibility_check.sv
// Reading change plausibility check. Each input word compares an earlier and a
// newer reading of one of four channel slots; the slot is mapped to a bus index
// and an unmapped or disabled bus, or a scan already stopped by a warning, is
// skipped. One result word is returned per input word. The block takes one word
// at a time: s_ready is high only while idle. A word that is skipped or settled by
// the zero, maximum or repeat tests goes from ST_CHECK through ST_FIN to ST_OUT.
// Otherwise the growth bound and, if it is not crossed, the decline bound are
// tested through the shared multiplier (ST_MUL_HI, ST_CMP_HI, ST_MUL_LO, ST_CMP_LO);
// a crossed bound has the 23-step restoring divider produce a ratio in ST_DIV. The
// block returns to idle once the result is taken. Configuration writes take effect
// at once and are meant only while the block is idle.
module reading_change_plausibility_check
    import rcpc_pkg::*;
#(
    parameter int BUS_SLOTS  = BUS_SLOTS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [SLOT_W-1:0]     s_channel_slot,
    input  logic [VAL_W-1:0]      s_prev_value,
    input  logic [VAL_W-1:0]      s_curr_value,
    input  logic                  s_last_of_scan,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_warning_code,
    output logic [IDX_W-1:0]      m_bus_index,
    output logic [RATIO_W-1:0]    m_ratio_percent,
    output logic                  m_skipped,
    output logic                  m_scan_warned
);

    localparam int VW   = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int EN_W = (BUS_SLOTS < EN_MAX) ? BUS_SLOTS : EN_MAX;

    seq_state_t state_reg, state_next;

    // Configuration registers
    logic [VAL_W-1:0]      max_value_reg;
    logic [PCT_W-1:0]      pct_reg;
    logic [CFG_DATA_W-1:0] map_reg;
    logic [EN_W-1:0]       en_reg;
    logic [RPT_W-1:0]      rwc_reg;

    // Current word
    logic             func_reg;
    logic             last_reg;
    logic [VW-1:0]    prev_reg;
    logic [VW-1:0]    curr_reg;
    logic [IDX_W-1:0] bus_reg;
    logic             skip_reg;
    warn_code_t       code_reg;
    logic [NUM_W-1:0] ratio_reg;
    logic [MUL_W-1:0] prod_reg;

    // Persistent state
    logic [CNT_W-1:0] cnt_reg [NUM_CODES];
    logic [RPT_W-1:0] rlimit_reg;
    logic             rpend_reg;
    logic             stopped_reg;

    // Combinational
    logic             accept;
    logic [IDX_W-1:0] slot_bus;
    logic             bus_hit;
    logic [VAL_W-1:0] prev_w;
    logic [VAL_W-1:0] curr_w;
    logic [VAL_W:0]   curr_p1;
    logic             prev_nz;
    logic             curr_nz;
    warn_code_t       chk_code;
    logic             chk_mul;
    logic [VAL_W:0]   mul_a;
    logic [MUL_W-1:0] mul_p;
    logic             grow;
    logic             decl;
    logic             mul_lo_sel;
    logic             div_start;
    logic [VAL_W-1:0] div_src;
    logic [VAL_W-1:0] div_den;
    logic [NUM_W-1:0] div_num;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    assign accept = s_valid && s_ready;

    // Map slot to bus index and look up its enable
    assign slot_bus = map_reg[{s_channel_slot, 3'b000} +: IDX_W];

    always_comb begin
        bus_hit = 1'b0;
        for (int i = 0; i < EN_W; i++) begin
            if (slot_bus == IDX_W'(i)) begin
                bus_hit = en_reg[i];
            end
        end
    end

    assign prev_w  = VAL_W'(prev_reg);
    assign curr_w  = VAL_W'(curr_reg);
    assign curr_p1 = {1'b0, curr_w} + 1'b1;
    assign prev_nz = prev_w != '0;
    assign curr_nz = curr_w != '0;

    // Tests that need no product
    always_comb begin
        chk_code = WARN_OK;
        chk_mul  = 1'b0;
        priority if (skip_reg) begin
            chk_code = WARN_OK;
        end else if (func_reg) begin
            if (prev_nz && curr_w == prev_w) begin
                chk_code = WARN_REPEAT;
            end
        end else if (prev_nz && !curr_nz) begin
            chk_code = WARN_ZERO;
        end else if (curr_w > max_value_reg) begin
            chk_code = WARN_MAX;
        end else if (prev_nz && curr_nz) begin
            chk_mul = 1'b1;
        end else begin
            chk_code = WARN_OK;
        end
    end

    // Shared multiplier: prev * limit, then (curr + 1) * limit
    assign mul_a = mul_lo_sel ? curr_p1 : {1'b0, prev_w};
    assign mul_p = MUL_W'(mul_a) * MUL_W'(pct_reg);

    // Growth: curr > floor(prev * limit / 100); decline: curr < floor(prev * 100 / limit)
    assign grow = (MUL_W'(curr_w) * MUL_W'(HUNDRED)) > prod_reg;
    assign decl = (pct_reg != '0) && (prod_reg <= MUL_W'(prev_w) * MUL_W'(HUNDRED));

    // Divider operands: newer over earlier reading for growth, earlier over newer for decline
    assign div_src = (state_reg == ST_CMP_HI) ? curr_w : prev_w;
    assign div_den = (state_reg == ST_CMP_HI) ? prev_w : curr_w;
    assign div_num = NUM_W'(div_src) * NUM_W'(HUNDRED);

    rcpc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = chk_mul ? ST_MUL_HI : ST_FIN;
            ST_MUL_HI: state_next = ST_CMP_HI;
            ST_CMP_HI: state_next = grow ? ST_DIV : ST_MUL_LO;
            ST_MUL_LO: state_next = ST_CMP_LO;
            ST_CMP_LO: state_next = decl ? ST_DIV : ST_FIN;
            ST_DIV:    if (div_done) state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:    if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        mul_lo_sel = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_CMP_HI: div_start  = grow;
            ST_MUL_LO: mul_lo_sel = 1'b1;
            ST_CMP_LO: div_start  = decl;
            ST_OUT:    m_valid    = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_value_reg <= MAX_RST;
            pct_reg       <= PCT_RST;
            map_reg       <= MAP_RST;
            en_reg        <= '0;
            rwc_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_VALUE:     max_value_reg <= cfg_data[VAL_W-1:0];
                REG_PERCENT_LIMIT: pct_reg       <= cfg_data[PCT_W-1:0];
                REG_CHANNEL_MAP:   map_reg       <= cfg_data;
                REG_BUS_ENABLE:    en_reg        <= cfg_data[EN_W-1:0];
                REG_REPEAT_COUNT:  rwc_reg       <= cfg_data[RPT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Word datapath: capture, classify, hold the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            last_reg <= s_last_of_scan;
            prev_reg <= s_prev_value[VW-1:0];
            curr_reg <= s_curr_value[VW-1:0];
            bus_reg  <= slot_bus;
            skip_reg <= stopped_reg || !bus_hit;
        end
        unique case (state_reg)
            ST_CHECK: begin
                code_reg  <= chk_code;
                ratio_reg <= '0;
            end
            ST_MUL_HI, ST_MUL_LO: prod_reg <= mul_p;
            ST_CMP_HI: if (grow) code_reg <= WARN_GROWTH;
            ST_CMP_LO: if (decl) code_reg <= WARN_DECLINE;
            ST_DIV:    if (div_done) ratio_reg <= div_quot;
            default:   ;
        endcase
    end

    // Warning bookkeeping and scan stop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CODES; k++) begin
                cnt_reg[k] <= '0;
            end
            rlimit_reg  <= '0;
            rpend_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FIN && code_reg != WARN_OK) begin
                for (int k = 0; k < NUM_CODES; k++) begin
                    if (code_reg == CODE_W'(k + 1)) begin
                        cnt_reg[k] <= cnt_reg[k] + 1'b1;
                    end
                end
                rlimit_reg  <= rwc_reg;
                rpend_reg   <= 1'b1;
                stopped_reg <= 1'b1;
            end else if (state_reg == ST_OUT && m_ready && last_reg) begin
                stopped_reg <= 1'b0;
            end
        end
    end

    assign m_warning_code  = code_reg;
    assign m_bus_index     = bus_reg;
    assign m_ratio_percent = RATIO_W'(ratio_reg);
    assign m_skipped       = skip_reg;
    assign m_scan_warned   = stopped_reg;

endmodule

>>> hdl/rcpc_checker.sv
`include "reading_change_plausibility_check_assert.svh"

module rcpc_checker
    import rcpc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic [CODE_W-1:0]  m_warning_code,
    input logic [RATIO_W-1:0] m_ratio_percent,
    input logic               m_skipped,
    input logic               m_scan_warned
);

    logic warn_free;
    logic ratio_code;

    assign warn_free  = m_warning_code == WARN_OK && m_ratio_percent == '0;
    assign ratio_code = m_warning_code == WARN_GROWTH || m_warning_code == WARN_DECLINE;

    // A skipped word carries no warning and no ratio
    `RCPC_ASSERT_SAME(a_skip_clean, m_valid && m_skipped, warn_free)

    // Ratio only accompanies growth or decline
    `RCPC_ASSERT_SAME(a_ratio_code, m_valid && !ratio_code, m_ratio_percent == '0)

    // Any warning marks the scan as warned
    `RCPC_ASSERT_SAME(a_warn_flag, m_valid && m_warning_code != WARN_OK, m_scan_warned)

    // One word at a time: busy right after acceptance
    `RCPC_ASSERT_NEXT(a_busy_after, s_valid && s_ready, !s_ready && !m_valid)

    // No new word while a result waits
    `RCPC_ASSERT_SAME(a_hold_input, m_valid, !s_ready)

endmodule

bind reading_change_plausibility_check rcpc_checker u_rcpc_checker (.*);
